// ----- rtl/link_sleep_state_accounting_unit_defines.svh -----
// Assertion macros for the link sleep-state accounting RTL, used by lssa_queue.
// Expects signals clk and arst_n in the scope of each use.
`ifndef LINK_SLEEP_STATE_ACCOUNTING_UNIT_DEFINES_SVH
`define LINK_SLEEP_STATE_ACCOUNTING_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LSSA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define LSSA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lssa_pkg.sv -----
// Types, constants and saturating helpers for the link sleep-state accounting unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package lssa_pkg;

	localparam int LINK_COUNT_DEF  = 2;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int TIME_W   = 48;
	localparam int CNT_W    = 32;
	localparam int WAKE_W   = 16;
	localparam int CHARGE_W = 34;
	localparam int REPORT_W = 33;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [TIME_W-1:0]   MAX48      = {TIME_W{1'b1}};
	localparam logic [CNT_W-1:0]    MAX32      = {CNT_W{1'b1}};
	localparam logic [CHARGE_W-1:0] MAX_CHARGE = 34'd8589934590;

	localparam logic [WAKE_W-1:0] WAKE_RST = 16'd100;
	localparam logic [CNT_W-1:0]  CHAN_RST = 32'd0;
	localparam logic [CNT_W-1:0]  MON_RST  = 32'd50000;

	typedef enum logic [1:0] {
		REG_WAKE    = 2'd0,
		REG_CHANNEL = 2'd1,
		REG_MONITOR = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_SLEEP = 2'd1,
		MODE_TX    = 2'd2
	} mode_t;

	typedef struct packed {
		logic [WAKE_W-1:0] wake_delay;
		logic [CNT_W-1:0]  channel_delay;
		logic [CNT_W-1:0]  monitor_interval;
	} cfg_t;

	// classified event, handed from front to back
	typedef struct packed {
		logic                in_range;
		logic                is_tx;
		logic                add_idle;
		logic                add_sleep;
		logic                count_entry;
		logic                direction;
		mode_t               mode_new;
		logic                suspended;
		logic [TIME_W-1:0]   elapsed;
		logic [CHARGE_W-1:0] charge;
		logic [TIME_W-1:0]   now;
		logic [TIME_W-1:0]   tick_ev;
	} item_t;

	typedef struct packed {
		mode_t               link_mode;
		logic [TIME_W-1:0]   event_time;
		logic                check_suspended;
		logic [REPORT_W-1:0] transmit_charge;
		logic [TIME_W-1:0]   idle_total;
		logic [TIME_W-1:0]   sleep_total;
		logic [TIME_W-1:0]   transmit_total;
		logic [CNT_W-1:0]    packet_count;
		logic [CNT_W-1:0]    sleep_entries;
	} result_t;

	function automatic logic [TIME_W-1:0] add_sat48(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? MAX48 : s[TIME_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] inc_sat32(input logic [CNT_W-1:0] a);
		return (a == MAX32) ? a : a + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/lssa_front.sv -----
// Front end: accepts events, tracks mode, sample time and suspension per link,
// and classifies each event into an item_t for the back end. Uses lssa_pkg.
`default_nettype none

module lssa_front import lssa_pkg::*; #(
	parameter int LINK_COUNT = LINK_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              action,
	input  wire logic              direction,
	input  wire logic [TIME_W-1:0] now_ns,
	input  wire logic [CNT_W-1:0]  tx_time_ns,
	input  wire logic              queue_full,
	output logic                   push,
	output item_t                  item
);

	localparam int LIDX_W = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;

	mode_t             mode_q [LINK_COUNT];
	logic [TIME_W-1:0] last_q [LINK_COUNT];
	logic              susp_q [LINK_COUNT];

	logic              in_range;
	logic [LIDX_W-1:0] idx;
	mode_t             mode_old;
	logic              susp_old;
	logic [TIME_W:0]   diff;
	logic [CNT_W-1:0]  penalty;
	logic              tick_susp;
	mode_t             tick_mode;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		in_range = (32'(direction) < 32'(LINK_COUNT));
		idx      = in_range ? LIDX_W'(direction) : '0;
		mode_old = mode_q[idx];
		susp_old = susp_q[idx];
		diff     = {1'b0, now_ns} - {1'b0, last_q[idx]};

		unique case (mode_old)
			MODE_IDLE: begin
				tick_mode = MODE_SLEEP;
				tick_susp = 1'b1;
			end
			MODE_SLEEP: begin
				tick_mode = MODE_SLEEP;
				tick_susp = susp_old;
			end
			default: begin
				tick_mode = MODE_IDLE;
				tick_susp = 1'b0;
			end
		endcase
		penalty = (mode_old == MODE_SLEEP) ? CNT_W'(cfg.wake_delay) : '0;

		item.in_range    = in_range;
		item.is_tx       = !action;
		item.add_idle    = (mode_old == MODE_IDLE);
		item.add_sleep   = (mode_old == MODE_SLEEP);
		item.count_entry = action && (mode_old == MODE_IDLE);
		item.direction   = direction;
		item.mode_new    = action ? tick_mode : MODE_TX;
		item.suspended   = action ? tick_susp : 1'b0;
		// time going backwards charges nothing
		item.elapsed     = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
		item.charge      = CHARGE_W'(tx_time_ns) + CHARGE_W'(cfg.channel_delay)
			+ CHARGE_W'(penalty);
		item.now         = now_ns;
		item.tick_ev     = tick_susp ? '0
			: add_sat48(now_ns, TIME_W'(cfg.monitor_interval));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINK_COUNT; i++) begin
				mode_q[i] <= MODE_IDLE;
				last_q[i] <= '0;
				susp_q[i] <= 1'b0;
			end
		end else if (push && in_range) begin
			mode_q[idx] <= item.mode_new;
			susp_q[idx] <= item.suspended;
			// only a tick moves the sample time
			if (action) begin
				last_q[idx] <= now_ns;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lssa_queue.sv -----
// Short FIFO of classified items between front and back end.
// Uses lssa_pkg for item_t and the assertion macros header.
`default_nettype none
`include "link_sleep_state_accounting_unit_defines.svh"

module lssa_queue import lssa_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t wr_item,
	output logic       full,
	output logic       not_empty,
	input  wire logic  pop,
	output item_t      rd_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`LSSA_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count above depth")
	`LSSA_ASSERT_NXT(a_push_grows, push && !pop, count_q == $past(count_q) + CNT_W'(1), "push lost")
	`LSSA_ASSERT_NXT(a_both_hold, push && pop, $stable(count_q) && (wr_ptr_q != $past(wr_ptr_q) || DEPTH == 1), "push and pop unbalanced")

endmodule

`default_nettype wire

// ----- rtl/lssa_back.sv -----
// Back end: pops classified items, updates the per-link totals and counters
// and holds the result in an output register. Uses lssa_pkg.
`default_nettype none

module lssa_back import lssa_pkg::*; #(
	parameter int LINK_COUNT = LINK_COUNT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire item_t q_item,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    result
);

	localparam int LIDX_W = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;

	logic [TIME_W-1:0] idle_q  [LINK_COUNT];
	logic [TIME_W-1:0] sleep_q [LINK_COUNT];
	logic [TIME_W-1:0] tx_q    [LINK_COUNT];
	logic [CNT_W-1:0]  pkt_q   [LINK_COUNT];
	logic [CNT_W-1:0]  entry_q [LINK_COUNT];

	logic              out_valid_q;
	result_t           res_q;

	logic [LIDX_W-1:0] idx;
	logic [TIME_W-1:0] idle_nx;
	logic [TIME_W-1:0] sleep_nx;
	logic [TIME_W-1:0] tx_nx;
	logic [CNT_W-1:0]  pkt_nx;
	logic [CNT_W-1:0]  entry_nx;
	result_t           res_nx;

	assign pop       = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = res_q;

	always_comb begin
		idx      = q_item.in_range ? LIDX_W'(q_item.direction) : '0;
		idle_nx  = q_item.add_idle ? add_sat48(idle_q[idx], q_item.elapsed) : idle_q[idx];
		sleep_nx = q_item.add_sleep ? add_sat48(sleep_q[idx], q_item.elapsed)
			: sleep_q[idx];
		tx_nx    = q_item.is_tx ? add_sat48(tx_q[idx], TIME_W'(q_item.charge)) : tx_q[idx];
		pkt_nx   = q_item.is_tx ? inc_sat32(pkt_q[idx]) : pkt_q[idx];
		entry_nx = q_item.count_entry ? inc_sat32(entry_q[idx]) : entry_q[idx];

		res_nx = '0;
		if (q_item.in_range) begin
			res_nx.link_mode       = q_item.mode_new;
			res_nx.check_suspended = q_item.suspended;
			res_nx.idle_total      = idle_nx;
			res_nx.sleep_total     = sleep_nx;
			res_nx.transmit_total  = tx_nx;
			res_nx.packet_count    = pkt_nx;
			res_nx.sleep_entries   = entry_nx;
			if (q_item.is_tx) begin
				res_nx.event_time      = add_sat48(q_item.now, TIME_W'(q_item.charge));
				res_nx.transmit_charge = (q_item.charge > MAX_CHARGE)
					? MAX_CHARGE[REPORT_W-1:0] : q_item.charge[REPORT_W-1:0];
			end else begin
				res_nx.event_time = q_item.tick_ev;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < LINK_COUNT; i++) begin
				idle_q[i]  <= '0;
				sleep_q[i] <= '0;
				tx_q[i]    <= '0;
				pkt_q[i]   <= '0;
				entry_q[i] <= '0;
			end
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && q_item.in_range) begin
				idle_q[idx]  <= idle_nx;
				sleep_q[idx] <= sleep_nx;
				tx_q[idx]    <= tx_nx;
				pkt_q[idx]   <= pkt_nx;
				entry_q[idx] <= entry_nx;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/link_sleep_state_accounting_unit.sv -----
// Link sleep-state accounting unit: top level with the APB register file.
// An accepted event goes into the queue, then its result into the output reg. While
// out_ready is high: one event per cycle; the back end retires one queue entry per cycle.
// The per-link state read-modify-write in the front and back end sets that rate.
// Reset (arst_n low, asynchronous): all modes idle, all totals, counters and times zero,
// registers to wake 100 ns, channel 0 ns, monitor 50000 ns; no clearing pass.
`default_nettype none

module link_sleep_state_accounting_unit import lssa_pkg::*; #(
	parameter int LINK_COUNT  = LINK_COUNT_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ADDR_W-1:0]   paddr,
	input  wire logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                action,
	input  wire logic                direction,
	input  wire logic [TIME_W-1:0]   now_ns,
	input  wire logic [CNT_W-1:0]    tx_time_ns,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               link_mode,
	output logic [TIME_W-1:0]        event_time_ns,
	output logic                     check_suspended,
	output logic [REPORT_W-1:0]      transmit_charge_ns,
	output logic [TIME_W-1:0]        idle_total_ns,
	output logic [TIME_W-1:0]        sleep_total_ns,
	output logic [TIME_W-1:0]        transmit_total_ns,
	output logic [CNT_W-1:0]         packet_count,
	output logic [CNT_W-1:0]         sleep_entries
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	logic     push;
	logic     q_full;
	logic     q_not_empty;
	logic     pop;
	item_t    wr_item;
	item_t    rd_item;
	result_t  result;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wake_delay       <= WAKE_RST;
			cfg_q.channel_delay    <= CHAN_RST;
			cfg_q.monitor_interval <= MON_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WAKE:    cfg_q.wake_delay       <= pwdata[WAKE_W-1:0];
				REG_CHANNEL: cfg_q.channel_delay    <= pwdata;
				REG_MONITOR: cfg_q.monitor_interval <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WAKE:    prdata = DATA_W'(cfg_q.wake_delay);
			REG_CHANNEL: prdata = cfg_q.channel_delay;
			REG_MONITOR: prdata = cfg_q.monitor_interval;
			default:     prdata = '0;
		endcase
	end

	lssa_front #(
		.LINK_COUNT (LINK_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.direction  (direction),
		.now_ns     (now_ns),
		.tx_time_ns (tx_time_ns),
		.queue_full (q_full),
		.push       (push),
		.item       (wr_item)
	);

	lssa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (wr_item),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (pop),
		.rd_item   (rd_item)
	);

	lssa_back #(
		.LINK_COUNT (LINK_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_item    (rd_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign link_mode          = result.link_mode;
	assign event_time_ns      = result.event_time;
	assign check_suspended    = result.check_suspended;
	assign transmit_charge_ns = result.transmit_charge;
	assign idle_total_ns      = result.idle_total;
	assign sleep_total_ns     = result.sleep_total;
	assign transmit_total_ns  = result.transmit_total;
	assign packet_count       = result.packet_count;
	assign sleep_entries      = result.sleep_entries;

endmodule

`default_nettype wire

// ----- test/tb_link_sleep_state_accounting_unit.sv -----
// Self-checking testbench for link_sleep_state_accounting_unit: valid/ready event and report
// channels, APB register writes between phases, and an in-bench model of the per-direction state.
// Depends on lssa_pkg and the unit's RTL only.

module tb_link_sleep_state_accounting_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lssa_pkg::*;

	localparam logic ACT_TX   = 1'b0;
	localparam logic ACT_TICK = 1'b1;
	localparam int   STALL_LIMIT = 5000;
	localparam int   PHASES = 6;

	typedef struct packed {
		logic              act;
		logic              dir;
		logic [TIME_W-1:0] now;
		logic [CNT_W-1:0]  tx;
	} link_event_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid, in_ready;
	logic                action, direction;
	logic [TIME_W-1:0]   now_ns;
	logic [CNT_W-1:0]    tx_time_ns;
	logic                out_valid, out_ready;
	logic [1:0]          link_mode;
	logic [TIME_W-1:0]   event_time_ns;
	logic                check_suspended;
	logic [REPORT_W-1:0] transmit_charge_ns;
	logic [TIME_W-1:0]   idle_total_ns, sleep_total_ns, transmit_total_ns;
	logic [CNT_W-1:0]    packet_count, sleep_entries;

	// register shadow
	logic [WAKE_W-1:0] wake_cfg;
	logic [CNT_W-1:0]  chan_cfg;
	logic [CNT_W-1:0]  mon_cfg;

	// per-direction accounting state
	mode_t             link_state[2];
	logic [TIME_W-1:0] sample_at[2];
	logic [TIME_W-1:0] idle_ns[2];
	logic [TIME_W-1:0] sleep_ns[2];
	logic [TIME_W-1:0] busy_ns[2];
	logic [CNT_W-1:0]  pkt_cnt[2];
	logic [CNT_W-1:0]  entry_cnt[2];
	logic              suspend[2];

	logic [TIME_W-1:0] wall_ns[2];

	link_event_t event_queue[$];
	result_t     expected_reports[$];

	logic in_taken = 1'b0;
	int   send_idle_pct, recv_stall_pct;
	int   stall_cycles = 0;
	int   mismatch_count = 0;
	int   tx_accepted = 0, ticks_accepted = 0, reports_checked = 0, settings_used = 1;

	link_sleep_state_accounting_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .direction(direction), .now_ns(now_ns), .tx_time_ns(tx_time_ns),
		.out_valid(out_valid), .out_ready(out_ready),
		.link_mode(link_mode), .event_time_ns(event_time_ns),
		.check_suspended(check_suspended), .transmit_charge_ns(transmit_charge_ns),
		.idle_total_ns(idle_total_ns), .sleep_total_ns(sleep_total_ns),
		.transmit_total_ns(transmit_total_ns), .packet_count(packet_count),
		.sleep_entries(sleep_entries)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [TIME_W-1:0] clamp_sum48(input logic [TIME_W-1:0] base,
			input logic [TIME_W-1:0] inc);
		logic [TIME_W:0] total;
		total = {1'b0, base} + {1'b0, inc};
		return (total > {1'b0, MAX48}) ? MAX48 : total[TIME_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] bump32(input logic [CNT_W-1:0] v);
		return v + CNT_W'(v != MAX32);
	endfunction

	// update one direction's state and return the report it produces
	function automatic result_t account_event(input logic act, input logic dir,
			input logic [TIME_W-1:0] now, input logic [CNT_W-1:0] tx);
		result_t             r;
		logic [TIME_W-1:0]   elapsed;
		logic [CHARGE_W-1:0] charge;
		logic [WAKE_W-1:0]   penalty;
		int                  d;
		d = int'(dir);
		r = '0;
		penalty = '0;
		elapsed = (now >= sample_at[d]) ? now - sample_at[d] : '0;
		if (act == ACT_TX) begin
			case (link_state[d])
				MODE_IDLE: idle_ns[d] = clamp_sum48(idle_ns[d], elapsed);
				MODE_SLEEP: begin
					sleep_ns[d] = clamp_sum48(sleep_ns[d], elapsed);
					penalty = wake_cfg;
				end
				default: ;
			endcase
			charge = CHARGE_W'(tx) + CHARGE_W'(chan_cfg) + CHARGE_W'(penalty);
			busy_ns[d] = clamp_sum48(busy_ns[d], TIME_W'(charge));
			link_state[d] = MODE_TX;
			pkt_cnt[d] = bump32(pkt_cnt[d]);
			suspend[d] = 1'b0;
			r.event_time = clamp_sum48(now, TIME_W'(charge));
			r.transmit_charge = (charge > MAX_CHARGE) ? REPORT_W'(MAX_CHARGE)
				: charge[REPORT_W-1:0];
		end else begin
			case (link_state[d])
				MODE_IDLE: begin
					link_state[d] = MODE_SLEEP;
					idle_ns[d] = clamp_sum48(idle_ns[d], elapsed);
					entry_cnt[d] = bump32(entry_cnt[d]);
					suspend[d] = 1'b1;
				end
				MODE_SLEEP: sleep_ns[d] = clamp_sum48(sleep_ns[d], elapsed);
				default: begin
					link_state[d] = MODE_IDLE;
					suspend[d] = 1'b0;
				end
			endcase
			sample_at[d] = now;
			r.event_time = suspend[d] ? '0 : clamp_sum48(now, TIME_W'(mon_cfg));
		end
		r.link_mode = link_state[d];
		r.check_suspended = suspend[d];
		r.idle_total = idle_ns[d];
		r.sleep_total = sleep_ns[d];
		r.transmit_total = busy_ns[d];
		r.packet_count = pkt_cnt[d];
		r.sleep_entries = entry_cnt[d];
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// accept transfers on both channels, predict and check
	always @(posedge clk) begin : monitor
		result_t want;
		logic    moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_reports.push_back(account_event(action, direction, now_ns, tx_time_ns));
				void'(event_queue.pop_front());
				in_taken = 1'b1;
				moved = 1'b1;
				if (action == ACT_TX)
					tx_accepted++;
				else
					ticks_accepted++;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (expected_reports.size() == 0) begin
					$error("report transfer with no event outstanding");
					mismatch_count++;
				end else begin
					want = expected_reports.pop_front();
					reports_checked++;
					compare_field("link_mode", TIME_W'(want.link_mode), TIME_W'(link_mode));
					compare_field("event_time_ns", want.event_time, event_time_ns);
					compare_field("check_suspended", TIME_W'(want.check_suspended),
						TIME_W'(check_suspended));
					compare_field("transmit_charge_ns", TIME_W'(want.transmit_charge),
						TIME_W'(transmit_charge_ns));
					compare_field("idle_total_ns", want.idle_total, idle_total_ns);
					compare_field("sleep_total_ns", want.sleep_total, sleep_total_ns);
					compare_field("transmit_total_ns", want.transmit_total, transmit_total_ns);
					compare_field("packet_count", TIME_W'(want.packet_count),
						TIME_W'(packet_count));
					compare_field("sleep_entries", TIME_W'(want.sleep_entries),
						TIME_W'(sleep_entries));
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// present the next pending event; hold it until transferred
	always @(negedge clk) begin : driver
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			in_taken = 1'b0;
			if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				action <= event_queue[0].act;
				direction <= event_queue[0].dir;
				now_ns <= event_queue[0].now;
				tx_time_ns <= event_queue[0].tx;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic push_event(input logic act, input logic dir, input logic [TIME_W-1:0] now,
			input logic [CNT_W-1:0] tx);
		event_queue.push_back('{act: act, dir: dir, now: now, tx: tx});
	endtask

	task automatic wait_drained();
		while (event_queue.size() != 0 || expected_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// write a register, then read it back
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] readback, want;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WAKE: wake_cfg = value[WAKE_W-1:0];
			REG_CHANNEL: chan_cfg = value;
			default: mon_cfg = value;
		endcase
		want = (idx == REG_WAKE) ? DATA_W'(value[WAKE_W-1:0]) : value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== want) begin
			$error("prdata: expected 0x%0h, got 0x%0h", want, readback);
			mismatch_count++;
		end
	endtask

	function automatic logic [CNT_W-1:0] pick_tx();
		int roll;
		roll = $urandom_range(7);
		if (roll == 0)
			return MAX32;
		else if (roll == 1)
			return $urandom;
		else if (roll == 2)
			return '0;
		return $urandom_range(2000, 1);
	endfunction

	// mostly ordered bursts on one direction; some time reversals and wild timestamps
	task automatic queue_random(input int count);
		int                left, burst, roll, step;
		logic              d;
		logic [TIME_W-1:0] stamp;
		left = count;
		while (left > 0) begin
			d = 1'($urandom_range(1));
			burst = $urandom_range(8, 1);
			for (int k = 0; k < burst && left > 0; k++) begin
				roll = $urandom_range(99);
				if (roll < 85) begin
					step = $urandom_range(7);
					if (step == 0)
						stamp = '0;
					else if (step < 4)
						stamp = TIME_W'($urandom_range(200, 1));
					else if (step < 7)
						stamp = TIME_W'($urandom_range(100000, 1));
					else
						stamp = TIME_W'($urandom);
					wall_ns[d] = clamp_sum48(wall_ns[d], stamp);
					stamp = wall_ns[d];
				end else if (roll < 92) begin
					stamp = wall_ns[d] - TIME_W'($urandom_range(5000));
				end else if (roll < 97) begin
					stamp = {16'($urandom), 32'($urandom)};
				end else begin
					stamp = MAX48 - TIME_W'($urandom_range(1000));
				end
				push_event(1'($urandom_range(1)), d, stamp, pick_tx());
				left--;
			end
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		action = ACT_TX;
		direction = 1'b0;
		now_ns = '0;
		tx_time_ns = '0;
		wake_cfg = WAKE_RST;
		chan_cfg = CHAN_RST;
		mon_cfg = MON_RST;
		for (int i = 0; i < 2; i++) begin
			link_state[i] = MODE_IDLE;
			sample_at[i] = '0;
			idle_ns[i] = '0;
			sleep_ns[i] = '0;
			busy_ns[i] = '0;
			pkt_cnt[i] = '0;
			entry_cnt[i] = '0;
			suspend[i] = 1'b0;
		end
		send_idle_pct = 22;
		recv_stall_pct = 86;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// direction 0: walk every mode change, then time going backwards
		push_event(ACT_TX, 1'b0, 48'd0, 32'd0);
		push_event(ACT_TICK, 1'b0, 48'd1000, 32'd0);
		push_event(ACT_TICK, 1'b0, 48'd3000, MAX32);
		push_event(ACT_TICK, 1'b0, 48'd9000, 32'd0);
		push_event(ACT_TX, 1'b0, 48'd12000, MAX32);
		push_event(ACT_TX, 1'b0, 48'd12500, 32'd10);
		push_event(ACT_TICK, 1'b0, 48'd13000, 32'd0);
		push_event(ACT_TICK, 1'b0, 48'd400, 32'd0);
		push_event(ACT_TX, 1'b0, 48'd200, 32'd5);
		// direction 1: drive totals and delivery/check times into saturation
		push_event(ACT_TICK, 1'b1, MAX48, 32'd0);
		push_event(ACT_TICK, 1'b1, 48'd0, 32'd0);
		push_event(ACT_TICK, 1'b1, MAX48, 32'd0);
		push_event(ACT_TICK, 1'b1, 48'd0, 32'd0);
		push_event(ACT_TICK, 1'b1, MAX48, 32'd0);
		push_event(ACT_TX, 1'b1, MAX48, MAX32);
		push_event(ACT_TICK, 1'b1, 48'd0, 32'd0);
		push_event(ACT_TX, 1'b1, MAX48, 32'd0);
		push_event(ACT_TICK, 1'b1, MAX48, 32'd0);
		wall_ns[0] = 48'd13000;
		wall_ns[1] = '0;

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				wait_drained();
				case (phase)
					1: begin
						write_reg(REG_WAKE, '0);
						write_reg(REG_CHANNEL, '0);
						write_reg(REG_MONITOR, 32'd1);
					end
					2: begin
						write_reg(REG_WAKE, DATA_W'(16'hFFFF));
						write_reg(REG_CHANNEL, 32'hFFFF_FFFF);
						write_reg(REG_MONITOR, 32'hFFFF_FFFF);
					end
					3: begin
						write_reg(REG_WAKE, DATA_W'($urandom_range(1000)));
						write_reg(REG_CHANNEL, DATA_W'($urandom_range(5000)));
						write_reg(REG_MONITOR, DATA_W'($urandom_range(200000, 1)));
					end
					4: begin
						write_reg(REG_WAKE, DATA_W'($urandom_range(16'hFFFF)));
						write_reg(REG_CHANNEL, $urandom);
						write_reg(REG_MONITOR, $urandom_range(32'hFFFF_FFFF, 1));
					end
					default: begin
						write_reg(REG_WAKE, DATA_W'(16'hFFFF));
						write_reg(REG_CHANNEL, '0);
						write_reg(REG_MONITOR, 32'd1);
					end
				endcase
				settings_used++;
			end
			if (phase < 2) begin
				send_idle_pct = 22;
				recv_stall_pct = 86;
			end else if (phase < 4) begin
				send_idle_pct = 86;
				recv_stall_pct = 22;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			queue_random((phase == 0) ? 160 : 175);
		end

		wait_drained();
		repeat (8) @(negedge clk);
		$display("Ran %0d transmit starts and %0d monitor ticks under %0d register settings;",
			tx_accepted, ticks_accepted, settings_used);
		$display("%0d reports compared, %0d mismatches.", reports_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lssa_pkg.sv
rtl/lssa_front.sv
rtl/lssa_queue.sv
rtl/lssa_back.sv
rtl/link_sleep_state_accounting_unit.sv
test/tb_link_sleep_state_accounting_unit.sv
